[rtl/lei_pkg.sv]
// Shared constants, types and helpers for the luma eight-tap interpolation filter.
`default_nettype none

package lei_pkg;

  // Field and datapath widths
  localparam int WIN_W     = 16;
  localparam int COEF_W    = 8;
  localparam int MAX_TAPS  = 8;
  localparam int TAPS_DEF  = 8;
  localparam int PROD_W    = WIN_W + COEF_W;
  localparam int SUM_W     = PROD_W + $clog2(MAX_TAPS);
  localparam int OUT_W     = 16;
  localparam int DEPTH_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int COEFF_W   = COEF_W * MAX_TAPS;

  // Scaling constants
  localparam int FRAC_BITS    = 6;
  localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);
  localparam int INTER_BITS   = 14;
  localparam int INTER_OFFSET = 8192;
  localparam int DEPTH_MIN    = 8;
  localparam int DEPTH_MAX    = 12;
  localparam int DEPTH_RESET  = 10;

  typedef logic signed [WIN_W-1:0]  win_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Output scaling modes
  typedef enum logic [1:0] {
    MODE_PEL         = 2'd0,
    MODE_INTER_OUT   = 2'd1,
    MODE_INTER_PEL   = 2'd2,
    MODE_INTER_INOUT = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF = 2'd0,
    REG_DEPTH = 2'd1,
    REG_MODE  = 2'd2,
    REG_NONE  = 2'd3
  } cfg_reg_t;

  // Limit bit depth to the supported range
  function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] r;
    if (d < DEPTH_W'(DEPTH_MIN)) begin
      r = DEPTH_W'(DEPTH_MIN);
    end else if (d > DEPTH_W'(DEPTH_MAX)) begin
      r = DEPTH_W'(DEPTH_MAX);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/lei_mult.sv]
// Tap multiplier stage: one registered 8x16 signed product per tap.
`default_nettype none

module lei_mult import lei_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire win_t               win [MAX_TAPS],
  input  wire logic [COEFF_W-1:0] coeff_pack,
  output logic                    prod_valid,
  output prod_t                   prod [TAPS]
);

  // Products carry no reset; the valid bit qualifies them
  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    always_ff @(posedge clk) begin
      prod[i] <= $signed(coeff_pack[COEF_W*i +: COEF_W]) * win[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

endmodule

`default_nettype wire

[rtl/lei_sum.sv]
// Two-level registered adder tree over the tap products.
`default_nettype none

module lei_sum import lei_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  prod_valid,
  input  wire prod_t prod [TAPS],
  output logic       sum_valid,
  output sum_t       sum
);

  localparam int PAIRS  = MAX_TAPS / 2;
  localparam int PAIR_W = PROD_W + 1;

  prod_t                     padded [MAX_TAPS];
  logic signed [PAIR_W-1:0]  pair   [PAIRS];
  logic                      pair_valid;

  // Unused taps contribute zero
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_pad
    if (j < TAPS) begin : g_used
      assign padded[j] = prod[j];
    end else begin : g_zero
      assign padded[j] = '0;
    end
  end

  // First level: pairwise sums
  for (genvar p = 0; p < PAIRS; p++) begin : g_pair
    always_ff @(posedge clk) begin
      pair[p] <= PAIR_W'(padded[2*p]) + PAIR_W'(padded[2*p+1]);
    end
  end

  // Second level: sum of the four pairs
  always_ff @(posedge clk) begin
    sum <= SUM_W'(pair[0]) + SUM_W'(pair[1]) + SUM_W'(pair[2]) + SUM_W'(pair[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      pair_valid <= prod_valid;
      sum_valid  <= pair_valid;
    end
  end

endmodule

`default_nettype wire

[rtl/lei_scale.sv]
// Output scaling stage: shift, round, clip or offset per mode, then register.
`default_nettype none

module lei_scale import lei_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sum_valid,
  input  wire sum_t               sum,
  input  wire logic [DEPTH_W-1:0] depth,
  input  wire mode_t              mode,
  output logic                    done,
  output logic signed [OUT_W-1:0] filtered
);

  localparam int EW = SUM_W + 1;

  logic [DEPTH_W-1:0]        d;
  logic [DEPTH_MAX:0]        pel_max;
  logic signed [EW-1:0]      pel_max_x;
  logic signed [EW-1:0]      sum_x;
  logic signed [EW-1:0]      rnd0;
  logic signed [EW-1:0]      sh0;
  logic signed [EW-1:0]      sh1;
  logic signed [EW-1:0]      sh2;
  logic signed [EW-1:0]      rnd2;
  logic signed [EW-1:0]      pel2;
  logic signed [EW-1:0]      sh3;
  logic signed [EW-1:0]      pel_in;
  logic signed [EW-1:0]      pel_clip;
  logic signed [OUT_W-1:0]   filtered_next;

  // Depth-dependent limits and shifts
  always_comb begin
    d         = clamp_depth(depth);
    pel_max   = ((DEPTH_MAX+1)'(1) << d) - (DEPTH_MAX+1)'(1);
    pel_max_x = $signed(EW'(pel_max));
    sum_x     = {sum[SUM_W-1], sum};
  end

  // Candidate results for each mode
  always_comb begin
    rnd0 = sum_x + EW'(ROUND_HALF);
    sh0  = rnd0 >>> FRAC_BITS;
    sh1  = sum_x >>> (d - DEPTH_W'(DEPTH_MIN));
    sh2  = sum_x >>> (DEPTH_W'(INTER_BITS) - d);
    rnd2 = sh2 + EW'(ROUND_HALF);
    pel2 = rnd2 >>> FRAC_BITS;
    sh3  = (sum_x >>> FRAC_BITS) - EW'(INTER_OFFSET);
  end

  // Pel clip to 0..2^depth-1
  always_comb begin
    pel_in = (mode == MODE_PEL) ? sh0 : pel2;
    if (pel_in < 0) begin
      pel_clip = '0;
    end else if (pel_in > pel_max_x) begin
      pel_clip = pel_max_x;
    end else begin
      pel_clip = pel_in;
    end
  end

  // Mode select; 16-bit modes wrap
  always_comb begin
    unique case (mode)
      MODE_PEL, MODE_INTER_PEL: filtered_next = pel_clip[OUT_W-1:0];
      MODE_INTER_OUT:           filtered_next = sh1[OUT_W-1:0];
      MODE_INTER_INOUT:         filtered_next = sh3[OUT_W-1:0];
      default:                  filtered_next = sh3[OUT_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    filtered <= filtered_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum_valid;
    end
  end

endmodule

`default_nettype wire

[rtl/luma_eight_tap_interpolation.sv]
// Top level of the luma eight-tap interpolation filter: config registers and pipeline.
//
//  Channel   Signals                               Transaction when
//  -------   ------------------------------------  ----------------------------
//  input     start, busy, win_0..win_7             start && !busy
//  result    done, filtered                        done (one cycle, no backpressure)
//  config    cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//            cfg_data
//
// One window is accepted every cycle; busy is always low. Each result passes
// through tap multipliers, pair sums, final sum and output scaling, each behind
// a register. Synchronous reset clears the valid bits and restores the
// registers (taps zero, depth 10, pel mode). Nothing stalls: the result
// strobe is never held off, so the pipeline only advances.
`default_nettype none

module luma_eight_tap_interpolation import lei_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [WIN_W-1:0] win_0,
  input  wire logic signed [WIN_W-1:0] win_1,
  input  wire logic signed [WIN_W-1:0] win_2,
  input  wire logic signed [WIN_W-1:0] win_3,
  input  wire logic signed [WIN_W-1:0] win_4,
  input  wire logic signed [WIN_W-1:0] win_5,
  input  wire logic signed [WIN_W-1:0] win_6,
  input  wire logic signed [WIN_W-1:0] win_7,
  output logic                       done,
  output logic signed [OUT_W-1:0]    filtered,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEFF_W-1:0]    cfg_data
);

  logic [COEFF_W-1:0] coeff_pack;
  logic [DEPTH_W-1:0] sample_depth;
  mode_t              filter_mode;

  win_t   win [MAX_TAPS];
  logic   in_valid;
  logic   prod_valid;
  prod_t  prod [TAPS];
  logic   sum_valid;
  sum_t   sum;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_valid  = start && !busy;

  assign win[0] = win_0;
  assign win[1] = win_1;
  assign win[2] = win_2;
  assign win[3] = win_3;
  assign win[4] = win_4;
  assign win[5] = win_5;
  assign win[6] = win_6;
  assign win[7] = win_7;

  // Configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_pack   <= '0;
      sample_depth <= DEPTH_W'(DEPTH_RESET);
      filter_mode  <= MODE_PEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEFF: coeff_pack   <= cfg_data;
        REG_DEPTH: sample_depth <= cfg_data[DEPTH_W-1:0];
        REG_MODE:  filter_mode  <= mode_t'(cfg_data[1:0]);
        REG_NONE:  ;
        default:   ;
      endcase
    end
  end

  lei_mult #(.TAPS(TAPS)) u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .win        (win),
    .coeff_pack (coeff_pack),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  lei_sum #(.TAPS(TAPS)) u_sum (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .sum_valid  (sum_valid),
    .sum        (sum)
  );

  lei_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum       (sum),
    .depth     (sample_depth),
    .mode      (filter_mode),
    .done      (done),
    .filtered  (filtered)
  );

endmodule

`default_nettype wire
